// ===== rtl/tgadec_pkg.sv =====
// Shared types and constants of the TGA 32-bit truecolor stream decoder.
`default_nettype none
package tgadec_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned OUT_TDATA_W = 104;

  localparam logic [4:0] HDR_LEN_LAST = 5'd17;
  localparam logic [4:0] HB_ID_LEN    = 5'd0;
  localparam logic [4:0] HB_CMAP_TYPE = 5'd1;
  localparam logic [4:0] HB_IMG_TYPE  = 5'd2;
  localparam logic [4:0] HB_W_LO      = 5'd12;
  localparam logic [4:0] HB_W_HI      = 5'd13;
  localparam logic [4:0] HB_H_LO      = 5'd14;
  localparam logic [4:0] HB_H_HI      = 5'd15;
  localparam logic [4:0] HB_DEPTH     = 5'd16;
  localparam logic [4:0] HB_DESC      = 5'd17;

  localparam logic [7:0] CMAP_NONE     = 8'd0;
  localparam logic [7:0] TYPE_TRUECOL  = 8'd2;
  localparam logic [7:0] DEPTH_32      = 8'd32;
  localparam int unsigned DESC_TOP_BIT = 5;

  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_FORMAT = 2'd1;
  localparam logic [1:0] ERR_TRUNC  = 2'd2;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_PIXEL  = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  // One command from the parser to the address generator.
  typedef struct packed {
    kind_t       kind;
    logic [1:0]  error_code;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic        rows_top_down;
    logic        last_pixel;
    logic        row_end;
    logic [31:0] pixel_rgba;
  } cmd_t;

endpackage
`default_nettype wire

// ===== rtl/tgadec_front.sv =====
// Byte parser: header capture, format check, ID skip and pixel assembly.
`default_nettype none
module tgadec_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [7:0]       in_tdata,
  input  wire logic             in_tuser,
  input  wire logic             q_full,
  output logic                  q_push,
  output tgadec_pkg::cmd_t      q_cmd
);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_ID_SKIP,
    PH_PIXELS,
    PH_DONE,
    PH_ERROR
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [4:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic [7:0]  id_len_r, id_len_nxt;
  logic [7:0]  id_left_r, id_left_nxt;
  logic [15:0] width_r, width_nxt;
  logic [15:0] height_r, height_nxt;
  logic        bad_r, bad_nxt;
  logic [1:0]  pix_cnt_r, pix_cnt_nxt;
  logic [23:0] partial_r, partial_nxt;
  logic [15:0] col_r, col_nxt;
  logic [15:0] row_r, row_nxt;

  logic        accept;
  logic        top_new;
  logic        empty;
  logic        col_end;
  logic        row_end;
  logic [16:0] col_inc;
  logic [16:0] row_inc;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign top_new   = in_tdata[tgadec_pkg::DESC_TOP_BIT];
  assign empty     = (width_r == 16'd0) || (height_r == 16'd0);
  assign col_inc   = {1'b0, col_r} + 17'd1;
  assign row_inc   = {1'b0, row_r} + 17'd1;
  assign col_end   = col_inc >= {1'b0, width_r};
  assign row_end   = row_inc >= {1'b0, height_r};

  always_comb begin
    phase_nxt   = phase_r;
    hdr_cnt_nxt = hdr_cnt_r;
    id_len_nxt  = id_len_r;
    id_left_nxt = id_left_r;
    width_nxt   = width_r;
    height_nxt  = height_r;
    bad_nxt     = bad_r;
    pix_cnt_nxt = pix_cnt_r;
    partial_nxt = partial_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    q_push      = 1'b0;
    q_cmd       = '0;

    if (accept) begin
      if (in_tuser) begin
        // End of stream: flag a short file if one is still open, then start over for the next one.
        q_push           = phase_r inside {PH_HEADER, PH_ID_SKIP, PH_PIXELS};
        q_cmd.kind       = tgadec_pkg::KIND_ERROR;
        q_cmd.error_code = tgadec_pkg::ERR_TRUNC;
        phase_nxt   = PH_HEADER;
        hdr_cnt_nxt = 5'd0;
        id_len_nxt  = 8'd0;
        id_left_nxt = 8'd0;
        width_nxt   = 16'd0;
        height_nxt  = 16'd0;
        bad_nxt     = 1'b0;
        pix_cnt_nxt = 2'd0;
        partial_nxt = 24'd0;
        col_nxt     = 16'd0;
        row_nxt     = 16'd0;
      end else begin
        case (phase_r)
          PH_HEADER: begin
            hdr_cnt_nxt = hdr_cnt_r + 5'd1;
            case (hdr_cnt_r)
              tgadec_pkg::HB_ID_LEN:    id_len_nxt = in_tdata;
              tgadec_pkg::HB_CMAP_TYPE: bad_nxt = bad_r || (in_tdata != tgadec_pkg::CMAP_NONE);
              tgadec_pkg::HB_IMG_TYPE:  bad_nxt = bad_r || (in_tdata != tgadec_pkg::TYPE_TRUECOL);
              tgadec_pkg::HB_W_LO:      width_nxt[7:0] = in_tdata;
              tgadec_pkg::HB_W_HI:      width_nxt[15:8] = in_tdata;
              tgadec_pkg::HB_H_LO:      height_nxt[7:0] = in_tdata;
              tgadec_pkg::HB_H_HI:      height_nxt[15:8] = in_tdata;
              tgadec_pkg::HB_DEPTH:     bad_nxt = bad_r || (in_tdata != tgadec_pkg::DEPTH_32);
              default: ;
            endcase
            if (hdr_cnt_r == tgadec_pkg::HDR_LEN_LAST) begin
              q_push = 1'b1;
              if (bad_r) begin
                q_cmd.kind       = tgadec_pkg::KIND_ERROR;
                q_cmd.error_code = tgadec_pkg::ERR_FORMAT;
                phase_nxt        = PH_ERROR;
              end else begin
                q_cmd.kind          = tgadec_pkg::KIND_HEADER;
                q_cmd.image_width   = width_r;
                q_cmd.image_height  = height_r;
                q_cmd.rows_top_down = top_new;
                q_cmd.last_pixel    = empty;
                col_nxt     = 16'd0;
                row_nxt     = 16'd0;
                pix_cnt_nxt = 2'd0;
                partial_nxt = 24'd0;
                if (empty) begin
                  phase_nxt = PH_DONE;
                end else begin
                  id_left_nxt = id_len_r;
                  phase_nxt   = (id_len_r != 8'd0) ? PH_ID_SKIP : PH_PIXELS;
                end
              end
            end
          end
          PH_ID_SKIP: begin
            id_left_nxt = id_left_r - 8'd1;
            if (id_left_r == 8'd1) begin
              phase_nxt = PH_PIXELS;
            end
          end
          PH_PIXELS: begin
            if (pix_cnt_r != 2'd3) begin
              partial_nxt[pix_cnt_r*8 +: 8] = in_tdata;
              pix_cnt_nxt = pix_cnt_r + 2'd1;
            end else begin
              q_push           = 1'b1;
              q_cmd.kind       = tgadec_pkg::KIND_PIXEL;
              q_cmd.pixel_rgba = {partial_r[23:16], partial_r[15:8], partial_r[7:0], in_tdata};
              q_cmd.last_pixel = col_end && row_end;
              q_cmd.row_end    = col_end;
              pix_cnt_nxt      = 2'd0;
              partial_nxt      = 24'd0;
              if (col_end && row_end) begin
                phase_nxt = PH_DONE;
              end else if (col_end) begin
                col_nxt = 16'd0;
                row_nxt = row_r + 16'd1;
              end else begin
                col_nxt = col_r + 16'd1;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      hdr_cnt_r <= 5'd0;
      id_len_r  <= 8'd0;
      id_left_r <= 8'd0;
      width_r   <= 16'd0;
      height_r  <= 16'd0;
      bad_r     <= 1'b0;
      pix_cnt_r <= 2'd0;
      partial_r <= 24'd0;
      col_r     <= 16'd0;
      row_r     <= 16'd0;
    end else begin
      phase_r   <= phase_nxt;
      hdr_cnt_r <= hdr_cnt_nxt;
      id_len_r  <= id_len_nxt;
      id_left_r <= id_left_nxt;
      width_r   <= width_nxt;
      height_r  <= height_nxt;
      bad_r     <= bad_nxt;
      pix_cnt_r <= pix_cnt_nxt;
      partial_r <= partial_nxt;
      col_r     <= col_nxt;
      row_r     <= row_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tgadec_fifo.sv =====
// Small command queue between the parser and the address generator.
`default_nettype none
module tgadec_fifo #(
  parameter int unsigned Depth = tgadec_pkg::QUEUE_DEPTH
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     push,
  input  wire tgadec_pkg::cmd_t         push_cmd,
  input  wire logic                     pop,
  output logic                          full,
  output logic                          not_empty,
  output tgadec_pkg::cmd_t              head_cmd,
  output logic [$clog2(Depth+1)-1:0]    count
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  tgadec_pkg::cmd_t mem_r [Depth];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]  count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full      = count_r == CntW'(Depth);
  assign not_empty = count_r != '0;
  assign head_cmd  = mem_r[rd_ptr_r];
  assign count     = count_r;
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tgadec_back.sv =====
// Address generator and output register: row base, column and result formatting.
`default_nettype none
module tgadec_back (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  q_not_empty,
  input  wire tgadec_pkg::cmd_t                      q_head,
  output logic                                       q_pop,
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  output logic [tgadec_pkg::OUT_TDATA_W-1:0]         out_tdata,
  output logic [1:0]                                 out_tuser,
  output logic                                       out_tlast
);

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [1:0]  err_r, err_nxt;
  logic [15:0] o_width_r, o_width_nxt;
  logic [15:0] o_height_r, o_height_nxt;
  logic        o_top_r, o_top_nxt;
  logic [31:0] rgba_r, rgba_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic        last_r, last_nxt;

  logic [15:0] width_r, width_nxt;
  logic        top_r, top_nxt;
  logic [15:0] col_r, col_nxt;
  logic [31:0] row_base_r, row_base_nxt;

  logic [15:0] height_m1;
  logic [31:0] bottom_base;

  assign q_pop       = q_not_empty && (!out_valid_r || out_tready);
  assign height_m1   = q_head.image_height - 16'd1;
  assign bottom_base = {16'd0, height_m1} * {16'd0, q_head.image_width};

  always_comb begin
    out_valid_nxt = out_valid_r;
    kind_nxt      = kind_r;
    err_nxt       = err_r;
    o_width_nxt   = o_width_r;
    o_height_nxt  = o_height_r;
    o_top_nxt     = o_top_r;
    rgba_nxt      = rgba_r;
    addr_nxt      = addr_r;
    last_nxt      = last_r;
    width_nxt     = width_r;
    top_nxt       = top_r;
    col_nxt       = col_r;
    row_base_nxt  = row_base_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (q_pop) begin
      out_valid_nxt = 1'b1;
      kind_nxt      = q_head.kind;
      err_nxt       = tgadec_pkg::ERR_NONE;
      o_width_nxt   = 16'd0;
      o_height_nxt  = 16'd0;
      o_top_nxt     = 1'b0;
      rgba_nxt      = 32'd0;
      addr_nxt      = 32'd0;
      last_nxt      = 1'b0;
      case (q_head.kind)
        tgadec_pkg::KIND_HEADER: begin
          o_width_nxt  = q_head.image_width;
          o_height_nxt = q_head.image_height;
          o_top_nxt    = q_head.rows_top_down;
          last_nxt     = q_head.last_pixel;
          width_nxt    = q_head.image_width;
          top_nxt      = q_head.rows_top_down;
          col_nxt      = 16'd0;
          // A bottom-up file starts at the last frame row.
          row_base_nxt = q_head.rows_top_down ? 32'd0 : bottom_base;
        end
        tgadec_pkg::KIND_PIXEL: begin
          rgba_nxt = q_head.pixel_rgba;
          addr_nxt = row_base_r + {16'd0, col_r};
          last_nxt = q_head.last_pixel;
          if (q_head.row_end) begin
            col_nxt      = 16'd0;
            row_base_nxt = top_r ? row_base_r + {16'd0, width_r}
                                 : row_base_r - {16'd0, width_r};
          end else begin
            col_nxt = col_r + 16'd1;
          end
        end
        default: begin
          err_nxt = q_head.error_code;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    kind_r     <= kind_nxt;
    err_r      <= err_nxt;
    o_width_r  <= o_width_nxt;
    o_height_r <= o_height_nxt;
    o_top_r    <= o_top_nxt;
    rgba_r     <= rgba_nxt;
    addr_r     <= addr_nxt;
    last_r     <= last_nxt;
    width_r    <= width_nxt;
    top_r      <= top_nxt;
    col_r      <= col_nxt;
    row_base_r <= row_base_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = kind_r;
  assign out_tlast  = last_r;
  assign out_tdata  = {5'd0, addr_r, rgba_r, o_top_r, o_height_r, o_width_r, err_r};

endmodule
`default_nettype wire

// ===== rtl/tga_bgra32_stream_decoder.sv =====
// Top level of the TGA 32-bit truecolor stream decoder.
//
// Channel | Direction | Payload
// in_     | slave     | tdata: byte_value[7:0]; tuser: func (1 = end of stream)
// out_    | master    | tdata: error_code, image_width, image_height, rows_top_down,
//         |           |        pixel_rgba, pixel_address; tuser: kind; tlast: last_pixel
//
// One byte is accepted every cycle while the queue is not full. The parser pushes a
// command into the queue at the edge that accepts the byte; the address generator loads
// the output register from the queue head when it is empty or its result is taken.
// The row base is updated by one add or subtract per row.
// Reset is synchronous and clears the parser, queue pointers and output valid flag.
// The queue absorbs short output stalls; in_tready falls only when it is full.
`default_nettype none
module tga_bgra32_stream_decoder #(
  parameter int unsigned QueueDepth = tgadec_pkg::QUEUE_DEPTH
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [7:0]                         in_tdata,   // [7:0] byte_value
  input  wire logic                               in_tuser,   // [0] func
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // [1:0] error_code, [17:2] image_width, [33:18] image_height, [34] rows_top_down,
  // [66:35] pixel_rgba, [98:67] pixel_address, [103:99] zero
  output logic [tgadec_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic [1:0]                              out_tuser,  // [1:0] kind
  output logic                                    out_tlast
);

  tgadec_pkg::cmd_t              push_cmd;
  tgadec_pkg::cmd_t              head_cmd;
  logic                          q_push;
  logic                          q_pop;
  logic                          q_full;
  logic                          q_not_empty;
  logic [$clog2(QueueDepth+1)-1:0] q_count;

  tgadec_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  tgadec_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_cmd  (head_cmd),
    .count     (q_count)
  );

  tgadec_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (head_cmd),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  // The queue never holds more commands than it has entries.
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= $bits(q_count)'(QueueDepth))
    else $error("command queue overflow");

  // A header that does not end the image must carry a nonzero size.
  a_header_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == tgadec_pkg::KIND_HEADER) && !out_tlast
      |-> (out_tdata[17:2] != 16'd0) && (out_tdata[33:18] != 16'd0))
    else $error("header result with empty size but no last flag");

  // Error results never close an image and always carry a code.
  a_error_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == tgadec_pkg::KIND_ERROR)
      |-> !out_tlast && (out_tdata[1:0] != tgadec_pkg::ERR_NONE))
    else $error("malformed error result");

  // Nothing is pushed while the queue is full.
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !in_tready)
    else $error("input accepted with queue full");

endmodule
`default_nettype wire

// ===== test/tb_tga_bgra32_stream_decoder.sv =====
// Self-checking testbench for the TGA 32-bit truecolor stream decoder.
`timescale 1ns / 1ps

typedef struct packed {
  tgadec_pkg::kind_t kind;
  logic [1:0]        error_code;
  logic [15:0]       width;
  logic [15:0]       height;
  logic              top_down;
  logic [31:0]       rgba;
  logic [31:0]       address;
  logic              last_pixel;
} tga_result_t;

// Tracks the decoder state per accepted byte and holds the results it must produce.
class tga_scoreboard;
  typedef enum logic [2:0] {PH_HEADER, PH_IDSKIP, PH_PIXELS, PH_DONE, PH_ERROR} phase_e;

  phase_e      phase;
  logic [4:0]  hdr_count;
  logic [7:0]  id_len;
  logic [7:0]  id_left;
  logic [15:0] width;
  logic [15:0] height;
  logic        top_down;
  logic        format_bad;
  logic [1:0]  pix_count;
  logic [23:0] partial_bgr;
  logic [15:0] col;
  logic [15:0] row;
  logic [31:0] row_base;
  tga_result_t expected_q[$];
  int          mismatches;
  int          results_seen;

  function new();
    restart();
    mismatches = 0;
    results_seen = 0;
  endfunction

  function void restart();
    phase = PH_HEADER;
    hdr_count = '0;
    id_len = '0;
    id_left = '0;
    width = '0;
    height = '0;
    top_down = 1'b0;
    format_bad = 1'b0;
    pix_count = '0;
    partial_bgr = '0;
    col = '0;
    row = '0;
    row_base = '0;
  endfunction

  function void note_input(logic eos, logic [7:0] b);
    tga_result_t r;
    logic [16:0] next_col;
    logic [16:0] next_row;
    logic        row_done;
    r = '0;
    if (eos) begin
      // An end marker while a file is still open means the file was cut short.
      if (phase == PH_HEADER || phase == PH_IDSKIP || phase == PH_PIXELS) begin
        r.kind = tgadec_pkg::KIND_ERROR;
        r.error_code = tgadec_pkg::ERR_TRUNC;
        expected_q.push_back(r);
      end
      restart();
      return;
    end
    case (phase)
      PH_HEADER: begin
        case (hdr_count)
          tgadec_pkg::HB_ID_LEN:    id_len = b;
          tgadec_pkg::HB_CMAP_TYPE: if (b != tgadec_pkg::CMAP_NONE) format_bad = 1'b1;
          tgadec_pkg::HB_IMG_TYPE:  if (b != tgadec_pkg::TYPE_TRUECOL) format_bad = 1'b1;
          tgadec_pkg::HB_W_LO:      width[7:0] = b;
          tgadec_pkg::HB_W_HI:      width[15:8] = b;
          tgadec_pkg::HB_H_LO:      height[7:0] = b;
          tgadec_pkg::HB_H_HI:      height[15:8] = b;
          tgadec_pkg::HB_DEPTH:     if (b != tgadec_pkg::DEPTH_32) format_bad = 1'b1;
          tgadec_pkg::HB_DESC:      top_down = b[tgadec_pkg::DESC_TOP_BIT];
          default: ;
        endcase
        if (hdr_count != tgadec_pkg::HDR_LEN_LAST) begin
          hdr_count++;
        end else if (format_bad) begin
          phase = PH_ERROR;
          r.kind = tgadec_pkg::KIND_ERROR;
          r.error_code = tgadec_pkg::ERR_FORMAT;
          expected_q.push_back(r);
        end else begin
          r.kind = tgadec_pkg::KIND_HEADER;
          r.width = width;
          r.height = height;
          r.top_down = top_down;
          r.last_pixel = (width == 16'd0 || height == 16'd0);
          col = '0;
          row = '0;
          pix_count = '0;
          partial_bgr = '0;
          if (r.last_pixel) begin
            phase = PH_DONE;
          end else begin
            // A bottom-up file starts on the last frame row.
            row_base = top_down ? 32'd0 : ({16'd0, height} - 32'd1) * {16'd0, width};
            id_left = id_len;
            phase = (id_left != 8'd0) ? PH_IDSKIP : PH_PIXELS;
          end
          expected_q.push_back(r);
        end
      end
      PH_IDSKIP: begin
        id_left--;
        if (id_left == 8'd0) phase = PH_PIXELS;
      end
      PH_PIXELS: begin
        if (pix_count != 2'd3) begin
          partial_bgr[8*pix_count +: 8] = b;
          pix_count++;
        end else begin
          next_col = {1'b0, col} + 17'd1;
          next_row = {1'b0, row} + 17'd1;
          row_done = (next_col >= {1'b0, width});
          r.kind = tgadec_pkg::KIND_PIXEL;
          r.rgba = {partial_bgr[23:16], partial_bgr[15:8], partial_bgr[7:0], b};
          r.address = row_base + {16'd0, col};
          r.last_pixel = row_done && (next_row >= {1'b0, height});
          pix_count = '0;
          partial_bgr = '0;
          if (r.last_pixel) begin
            phase = PH_DONE;
          end else if (row_done) begin
            col = '0;
            row = next_row[15:0];
            row_base = top_down ? row_base + {16'd0, width} : row_base - {16'd0, width};
          end else begin
            col = next_col[15:0];
          end
          expected_q.push_back(r);
        end
      end
      default: ;
    endcase
  endfunction

  function void flag(string field, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s: expected %h, got %h", field, want, got);
  endfunction

  function void check_result(logic [1:0] kind, logic [tgadec_pkg::OUT_TDATA_W-1:0] data,
                             logic last);
    tga_result_t want;
    results_seen++;
    if (expected_q.size() == 0) begin
      flag("result with nothing pending (kind)", 32'd0, {30'd0, kind});
      return;
    end
    want = expected_q.pop_front();
    if (kind !== want.kind) flag("kind", want.kind, kind);
    if (data[1:0] !== want.error_code) flag("error_code", want.error_code, data[1:0]);
    if (data[17:2] !== want.width) flag("image_width", want.width, data[17:2]);
    if (data[33:18] !== want.height) flag("image_height", want.height, data[33:18]);
    if (data[34] !== want.top_down) flag("rows_top_down", want.top_down, data[34]);
    if (data[66:35] !== want.rgba) flag("pixel_rgba", want.rgba, data[66:35]);
    if (data[98:67] !== want.address) flag("pixel_address", want.address, data[98:67]);
    if (data[103:99] !== 5'd0) flag("tdata padding", 32'd0, data[103:99]);
    if (last !== want.last_pixel) flag("last_pixel", want.last_pixel, last);
  endfunction
endclass

module tb_tga_bgra32_stream_decoder;
  localparam int ITEM_TARGET = 650;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AFTER_RESULTS = 20;

  typedef enum int {
    SC_GOOD, SC_EMPTY, SC_BAD_CMAP, SC_BAD_TYPE, SC_BAD_DEPTH, SC_CUT_HEADER,
    SC_CUT_ID, SC_CUT_PIXELS, SC_HUGE, SC_LONG_ID, SC_LONE_EOS, SC_COUNT
  } scenario_e;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [7:0] in_tdata;
  logic in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [tgadec_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [1:0] out_tuser;
  logic out_tlast;

  tga_scoreboard sb;
  int items_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  always #2 clk = ~clk;

  tga_bgra32_stream_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Results are checked before the byte of the same edge is noted; a byte never
  // produces its result at the edge that accepts it.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata, out_tlast);
      if (in_tvalid && in_tready) sb.note_input(in_tuser, in_tdata);
    end
  end

  // Receiver: random stalls, plus one long hold-off that fills the block up.
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && sb != null && sb.results_seen >= HOLD_AFTER_RESULTS) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_item(input logic eos, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= eos;
    in_tdata <= b;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  task automatic send_eos();
    send_item(1'b1, 8'($urandom_range(255)));
  endtask

  // Sends the first hdr_n header bytes and, after a whole header, body_n random bytes.
  task automatic send_file(input logic [7:0] id_len, input logic [7:0] cmap,
                           input logic [7:0] itype, input logic [7:0] depth,
                           input logic [7:0] desc, input logic [15:0] w,
                           input logic [15:0] h, input int hdr_n, input int body_n);
    logic [7:0] hdr [18];
    for (int i = 0; i < 18; i++) hdr[i] = 8'($urandom_range(255));
    hdr[tgadec_pkg::HB_ID_LEN] = id_len;
    hdr[tgadec_pkg::HB_CMAP_TYPE] = cmap;
    hdr[tgadec_pkg::HB_IMG_TYPE] = itype;
    hdr[tgadec_pkg::HB_W_LO] = w[7:0];
    hdr[tgadec_pkg::HB_W_HI] = w[15:8];
    hdr[tgadec_pkg::HB_H_LO] = h[7:0];
    hdr[tgadec_pkg::HB_H_HI] = h[15:8];
    hdr[tgadec_pkg::HB_DEPTH] = depth;
    hdr[tgadec_pkg::HB_DESC] = desc;
    for (int i = 0; i < hdr_n; i++) send_item(1'b0, hdr[i]);
    if (hdr_n == 18)
      for (int i = 0; i < body_n; i++) send_item(1'b0, 8'($urandom_range(255)));
  endtask

  task automatic send_scenario(input scenario_e scen);
    logic [7:0] id_len;
    logic [7:0] cmap;
    logic [7:0] itype;
    logic [7:0] depth;
    logic [7:0] desc;
    logic [15:0] w;
    logic [15:0] h;
    int hdr_n;
    int body_n;
    int ignored;
    id_len = 8'($urandom_range(3));
    cmap = tgadec_pkg::CMAP_NONE;
    itype = tgadec_pkg::TYPE_TRUECOL;
    depth = tgadec_pkg::DEPTH_32;
    desc = 8'($urandom_range(255));
    w = 16'($urandom_range(4, 1));
    h = 16'($urandom_range(4, 1));
    hdr_n = 18;
    body_n = 0;
    ignored = 0;
    case (scen)
      SC_GOOD: begin
        if ($urandom_range(7) == 0) id_len = 8'($urandom_range(40));
        ignored = $urandom_range(2);
        body_n = id_len + 4 * w * h + ignored;
      end
      SC_EMPTY: begin
        id_len = 8'($urandom_range(255));
        case ($urandom_range(2))
          0: begin w = 16'd0; h = 16'($urandom_range(65535)); end
          1: begin h = 16'd0; w = 16'($urandom_range(65535)); end
          default: begin w = 16'd0; h = 16'd0; end
        endcase
        body_n = $urandom_range(3);
        ignored = body_n;
      end
      SC_BAD_CMAP, SC_BAD_TYPE, SC_BAD_DEPTH: begin
        w = 16'($urandom_range(65535));
        h = 16'($urandom_range(65535));
        if (scen == SC_BAD_CMAP) cmap = 8'($urandom_range(255, 1));
        if (scen == SC_BAD_TYPE) begin
          itype = 8'($urandom_range(255));
          if (itype == tgadec_pkg::TYPE_TRUECOL) itype = 8'd10;
        end
        if (scen == SC_BAD_DEPTH) begin
          depth = 8'($urandom_range(255));
          if (depth == tgadec_pkg::DEPTH_32) depth = 8'd24;
        end
        body_n = $urandom_range(3);
        ignored = body_n;
      end
      SC_CUT_HEADER: hdr_n = $urandom_range(17, 1);
      SC_CUT_ID: begin
        id_len = 8'($urandom_range(20, 1));
        body_n = $urandom_range(id_len - 1, 0);
      end
      SC_CUT_PIXELS: body_n = id_len + $urandom_range(4 * w * h - 1, 0);
      SC_HUGE: begin
        // Large frames exercise the full width and height fields and the
        // bottom-up start address; only a few pixels are sent.
        w = 16'($urandom_range(65535, 1));
        if ($urandom_range(1)) h = 16'($urandom_range(65535, 1));
        if ($urandom_range(1)) begin
          h = w;
          w = 16'($urandom_range(3, 1));
        end
        body_n = id_len + $urandom_range(40, 1);
      end
      SC_LONG_ID: begin
        id_len = 8'($urandom_range(255, 128));
        w = 16'($urandom_range(2, 1));
        h = 16'd1;
        body_n = id_len + 4 * w * h;
      end
      default: hdr_n = 0;
    endcase
    send_file(id_len, cmap, itype, depth, desc, w, h, hdr_n, body_n);
    send_eos();
    items_sent -= ignored;
  endtask

  initial begin
    int file_idx;
    int idle_phase;
    scenario_e scen;
    sb = new();
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser <= 1'b0;
    in_tdata <= 8'd0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: an end marker before any header byte, then a one-pixel top-down file
    // followed by an end marker in the done phase.
    send_eos();
    send_file(8'd0, tgadec_pkg::CMAP_NONE, tgadec_pkg::TYPE_TRUECOL, tgadec_pkg::DEPTH_32,
              8'(1 << tgadec_pkg::DESC_TOP_BIT), 16'd1, 16'd1, 18, 0);
    send_item(1'b0, 8'hFF);
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'hFF);
    send_item(1'b0, 8'h00);
    send_eos();

    // Random files; the first pass walks through every scenario once.
    file_idx = 0;
    while (items_sent < ITEM_TARGET) begin
      idle_phase = (items_sent * 4) / ITEM_TARGET;
      case (idle_phase)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 53; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 53; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      if (file_idx < SC_COUNT) scen = scenario_e'(file_idx);
      else if ($urandom_range(9) < 6) scen = SC_GOOD;
      else scen = scenario_e'($urandom_range(SC_COUNT - 1));
      send_scenario(scen);
      file_idx++;
    end
    in_tvalid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/tgadec_pkg.sv
rtl/tgadec_front.sv
rtl/tgadec_fifo.sv
rtl/tgadec_back.sv
rtl/tga_bgra32_stream_decoder.sv
test/tb_tga_bgra32_stream_decoder.sv
